// ===== hw/rtl/rhp_pkg.sv =====
// Shared types and constants for the RTP header parser.
// Used by the input stage, the parse stage and the top level; no dependencies.

package rhp_pkg;

  // Result kind codes.
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_CSRC    = 3'd1,
    KIND_EXT     = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_REJECT  = 3'd4
  } kind_t;

  // Header field positions, version code, length limit and history reset value.
  localparam logic [1:0] HDR_VERSION     = 2'd2;
  localparam int         HDR_LAST_POS    = 9;
  localparam int         STAMP_LAST_POS  = 5;
  localparam int         WORD_LAST_POS   = 3;
  localparam logic [11:0] HDR_MIN_BYTES  = 12'd12;
  localparam logic [15:0] LAST_SEQ_RESET = 16'd1;

  // One input beat.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [11:0] plen;
    logic [15:0] seq;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq;
    logic        marker;
    logic [6:0]  media_type;
    logic [3:0]  csrc_count;
    logic        has_extension;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [15:0] ext_kind;
    logic        late;
    logic [31:0] data_word;
    logic        end_of_packet;
  } res_beat_t;

endpackage

// ===== hw/rtl/rhp_in_reg.sv =====
// Input register stage of the RTP header parser.
// Depends on rhp_pkg for the beat type.

module rhp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rhp_pkg::in_beat_t in_beat,
  output logic              beat_valid,
  output rhp_pkg::in_beat_t beat,
  input  logic              beat_take
);
  import rhp_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // The register is free when empty or when its beat moves on this cycle.
  assign in_stall   = valid_r && !beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ===== hw/rtl/rhp_parse.sv =====
// Parse stage of the RTP header parser: packet state, checks and result register.
// Depends on rhp_pkg for the beat types and header constants.

module rhp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_valid,
  input  rhp_pkg::in_beat_t  beat,
  output logic               beat_take,
  output logic               res_valid,
  output rhp_pkg::res_beat_t res,
  input  logic               res_stall
);
  import rhp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_CSRC = 3'd1,
    PH_EXTH = 3'd2,
    PH_EXTW = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  mt_r, mt_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] ssrc_r, ssrc_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [15:0] wl_r, wl_nxt;
  logic [15:0] ext_r, ext_nxt;
  logic        drop_r, drop_nxt;
  logic [15:0] lseq_r, lseq_nxt;
  logic [31:0] lstamp_r, lstamp_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_beat_t   res_r, res_nxt;

  // A beat is processed whenever the result register can take a new value.
  assign beat_take = beat_valid && (!out_valid_r || !res_stall);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // Next state and result for the beat in the input register.
  always_comb begin
    logic        has;
    logic        rej;
    logic        late;
    logic        swallow;
    kind_t       kind;
    logic [31:0] data;
    logic [11:0] min_len;
    logic [15:0] wl_dec;

    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    flag_nxt   = flag_r;
    mt_nxt     = mt_r;
    stamp_nxt  = stamp_r;
    ssrc_nxt   = ssrc_r;
    ws_nxt     = ws_r;
    wl_nxt     = wl_r;
    ext_nxt    = ext_r;
    drop_nxt   = drop_r;
    lseq_nxt   = lseq_r;
    lstamp_nxt = lstamp_r;
    has        = 1'b0;
    rej        = 1'b0;
    late       = 1'b0;
    kind       = KIND_HEADER;
    data       = '0;
    min_len    = HDR_MIN_BYTES + {6'd0, beat.data[3:0], 2'b00};
    wl_dec     = wl_r - 16'd1;

    // A first beat abandons whatever packet was in progress.
    if (beat.first) begin
      phase_nxt = PH_HEAD;
      pos_nxt   = '0;
      drop_nxt  = 1'b0;
      ws_nxt    = '0;
      wl_nxt    = '0;
      ext_nxt   = '0;
      wl_dec    = 16'hFFFF;
    end
    swallow = drop_nxt;

    if (swallow) begin
      // Swallow the rest of a rejected packet.
      if (beat.last) begin
        phase_nxt = PH_HEAD;
        pos_nxt   = '0;
        drop_nxt  = 1'b0;
        ws_nxt    = '0;
        wl_nxt    = '0;
        ext_nxt   = '0;
      end
    end else begin
      case (phase_nxt)
        PH_HEAD: begin
          if (pos_nxt == 4'd0) begin
            flag_nxt = beat.data;
            if (beat.data[7:6] != HDR_VERSION || beat.data[3:0] == 4'd0 ||
                beat.plen < min_len) begin
              rej = 1'b1;
            end
          end else if (pos_nxt == 4'd1) begin
            mt_nxt = beat.data;
          end else if (pos_nxt <= 4'(STAMP_LAST_POS)) begin
            stamp_nxt = {stamp_nxt[23:0], beat.data};
          end else begin
            ssrc_nxt = {ssrc_nxt[23:0], beat.data};
          end
          if (!rej) begin
            if (pos_nxt == 4'(HDR_LAST_POS)) begin
              has       = 1'b1;
              kind      = KIND_HEADER;
              wl_nxt    = {12'd0, flag_nxt[3:0]};
              ws_nxt    = '0;
              pos_nxt   = '0;
              phase_nxt = PH_CSRC;
            end else begin
              pos_nxt = pos_nxt + 4'd1;
            end
          end
        end
        PH_CSRC, PH_EXTW: begin
          ws_nxt = {ws_nxt[23:0], beat.data};
          if (pos_nxt == 4'(WORD_LAST_POS)) begin
            has     = 1'b1;
            kind    = (phase_nxt == PH_CSRC) ? KIND_CSRC : KIND_EXT;
            data    = ws_nxt;
            pos_nxt = '0;
            ws_nxt  = '0;
            wl_nxt  = wl_dec;
            if (wl_dec == 16'd0) begin
              if (phase_nxt == PH_CSRC && flag_nxt[4]) begin
                phase_nxt = PH_EXTH;
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          end else begin
            pos_nxt = pos_nxt + 4'd1;
          end
        end
        PH_EXTH: begin
          if (pos_nxt == 4'd0) begin
            wl_nxt = {beat.data, 8'd0};
          end else if (pos_nxt == 4'd1) begin
            wl_nxt = {wl_nxt[15:8], beat.data};
            if ({wl_nxt, 2'b00} > {6'd0, beat.plen}) begin
              rej = 1'b1;
            end
          end else if (pos_nxt == 4'd2) begin
            ext_nxt = {beat.data, 8'd0};
          end else begin
            ext_nxt = {ext_nxt[15:8], beat.data};
          end
          if (!rej) begin
            if (pos_nxt == 4'(WORD_LAST_POS)) begin
              pos_nxt   = '0;
              ws_nxt    = '0;
              phase_nxt = (wl_nxt != 16'd0) ? PH_EXTW : PH_PAY;
            end else begin
              pos_nxt = pos_nxt + 4'd1;
            end
          end
        end
        PH_PAY: begin
          has  = 1'b1;
          kind = KIND_PAYLOAD;
          data = {24'd0, beat.data};
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end

    // Late check against the last accepted packet.
    late = (beat.seq < lseq_r) && (stamp_nxt < lstamp_r);

    // An early end rejects the packet; a complete one may update the history.
    if (!swallow && !rej && beat.last) begin
      if (phase_nxt != PH_PAY) begin
        rej = 1'b1;
      end else if (!late) begin
        lseq_nxt   = beat.seq;
        lstamp_nxt = stamp_nxt;
      end
    end

    // Result beat.
    res_nxt               = '0;
    res_nxt.seq           = beat.seq;
    out_valid_nxt         = 1'b0;
    if (rej) begin
      out_valid_nxt         = 1'b1;
      res_nxt.kind          = KIND_REJECT;
      res_nxt.end_of_packet = 1'b1;
    end else if (has) begin
      out_valid_nxt         = 1'b1;
      res_nxt.kind          = kind;
      res_nxt.marker        = mt_nxt[7];
      res_nxt.media_type    = mt_nxt[6:0];
      res_nxt.csrc_count    = flag_nxt[3:0];
      res_nxt.has_extension = flag_nxt[4];
      res_nxt.time_stamp    = stamp_nxt;
      res_nxt.source_id     = ssrc_nxt;
      res_nxt.ext_kind      = ext_nxt;
      res_nxt.late          = late;
      res_nxt.data_word     = data;
      res_nxt.end_of_packet = beat.last;
    end

    // Rejection swallows the rest, unless this was the last beat.
    if (rej && !beat.last) begin
      drop_nxt = 1'b1;
    end else if (beat.last) begin
      phase_nxt = PH_HEAD;
      pos_nxt   = '0;
      drop_nxt  = 1'b0;
      ws_nxt    = '0;
      wl_nxt    = '0;
      ext_nxt   = '0;
    end
  end

  // Packet state and history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEAD;
      pos_r    <= '0;
      flag_r   <= '0;
      mt_r     <= '0;
      stamp_r  <= '0;
      ssrc_r   <= '0;
      ws_r     <= '0;
      wl_r     <= '0;
      ext_r    <= '0;
      drop_r   <= 1'b0;
      lseq_r   <= LAST_SEQ_RESET;
      lstamp_r <= '0;
    end else if (beat_take) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      flag_r   <= flag_nxt;
      mt_r     <= mt_nxt;
      stamp_r  <= stamp_nxt;
      ssrc_r   <= ssrc_nxt;
      ws_r     <= ws_nxt;
      wl_r     <= wl_nxt;
      ext_r    <= ext_nxt;
      drop_r   <= drop_nxt;
      lseq_r   <= lseq_nxt;
      lstamp_r <= lstamp_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_take) begin
      out_valid_r <= out_valid_nxt;
    end else if (!res_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (beat_take && out_valid_nxt) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== hw/rtl/rtp_header_parser_top.sv =====
// RTP header parser: one body byte per beat in, header, CSRC, extension,
// payload and reject results out. An accepted beat passes the input register and
// then the result register; a new beat is taken every cycle unless the result
// register stalls. The per-byte state update in the parse stage sets that rate.
// Reset is synchronous and active low; the history starts at sequence 1.
// Depends on rhp_pkg, rhp_in_reg and rhp_parse.

module rtp_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [11:0] in_packet_length,
  input  logic [15:0] in_seq_num,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_seq_out,
  output logic        out_marker,
  output logic [6:0]  out_media_type,
  output logic [3:0]  out_csrc_count,
  output logic        out_has_extension,
  output logic [31:0] out_time_stamp,
  output logic [31:0] out_source_id,
  output logic [15:0] out_ext_kind,
  output logic        out_late,
  output logic [31:0] out_data_word,
  output logic        out_end_of_packet
);
  import rhp_pkg::*;

  in_beat_t  in_beat;
  in_beat_t  beat;
  logic      beat_valid;
  logic      beat_take;
  res_beat_t res;

  // Gather the input fields into one beat.
  always_comb begin
    in_beat.data  = in_byte;
    in_beat.first = in_first_byte;
    in_beat.last  = in_last_byte;
    in_beat.plen  = in_packet_length;
    in_beat.seq   = in_seq_num;
  end

  rhp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  rhp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .res_valid  (out_valid),
    .res        (res),
    .res_stall  (out_stall)
  );

  // Spread the result beat over the output ports.
  assign out_kind          = res.kind;
  assign out_seq_out       = res.seq;
  assign out_marker        = res.marker;
  assign out_media_type    = res.media_type;
  assign out_csrc_count    = res.csrc_count;
  assign out_has_extension = res.has_extension;
  assign out_time_stamp    = res.time_stamp;
  assign out_source_id     = res.source_id;
  assign out_ext_kind      = res.ext_kind;
  assign out_late          = res.late;
  assign out_data_word     = res.data_word;
  assign out_end_of_packet = res.end_of_packet;

endmodule
